### rtl/pfps_pkg.sv
// Package for the potential field path stepper: word types, codes and
// fixed-point helpers. Used by the top module and pfps_div; depends on nothing.
`timescale 1ns / 1ps

package pfps_pkg;

   // Item kinds.
   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_ADD   = 2'd1;
   localparam logic [1:0] KIND_STEP  = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_ZERO = 2'd2;

   // Register indexes on the csr port.
   localparam logic [2:0] CSR_TARGET_X      = 3'd0;
   localparam logic [2:0] CSR_TARGET_Y      = 3'd1;
   localparam logic [2:0] CSR_STEP_DISTANCE = 3'd2;
   localparam logic [2:0] CSR_ATTRACTION    = 3'd3;
   localparam logic [2:0] CSR_ARRIVE_RADIUS = 3'd4;

   // Width of a vector magnitude: isqrt of a 63-bit sum, shifted up by two.
   localparam int MAG_W = 34;

   localparam logic [30:0] SAT_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] obstacle_x;
      logic signed [31:0] obstacle_y;
      logic [30:0]        obstacle_weight;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic               arrived;
      logic [1:0]         status;
   } rsp_word_type;

   function automatic logic [32:0] abs33(input logic signed [32:0] v);
      abs33 = v[32] ? 33'(-v) : 33'(v);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sh0_7FFF_FFFF) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < -66'sh0_8000_0000) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

### rtl/potential_field_path_stepper.sv
// Potential-field path stepper: obstacle table, sequencer and state.
// Depends on pfps_pkg, pfps_mul, pfps_div and pfps_sqrt.
//
// Usage. Words enter on req_ (valid/stall); kind clears the position,
// force and obstacle table, adds an obstacle, or takes one step. Each word
// gives exactly one result word on rsp_ with the position afterwards, the
// arrival flag and a status. Registers on the csr_ port must be written only
// while the block is idle; the block itself does not enforce this.
// One magnitude takes two multiplies and a square root. For a step that
// does not arrive, the shared restoring divider, DW bits wide (64 at the
// default FRAC_BITS), does six divisions per force term. One word is worked
// on at a time, so the next word is taken only after the result is loaded;
// req_stall is high from acceptance until the result is loaded into the
// output register.
// Reset clears position, force, obstacle count and registers to their
// defaults; there is no clearing pass. A stalled result holds in the output
// register while the next word is accepted; a finished word waits for the
// register to empty before it is loaded.
`timescale 1ns / 1ps

module potential_field_path_stepper #(
   parameter int MAX_OBSTACLES = 16,
   parameter int FRAC_BITS     = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pfps_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pfps_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wdata
);
   import pfps_pkg::*;

   localparam int DW = (32 + 2 * FRAC_BITS > 64) ? 32 + 2 * FRAC_BITS : 64;
   localparam int CW = $clog2(MAX_OBSTACLES + 1);
   localparam int IW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

   typedef enum logic [19:0] {
      ST_IDLE     = 20'h00001,
      ST_MAG_X    = 20'h00002,
      ST_MAG_Y    = 20'h00004,
      ST_MAG_S    = 20'h00008,
      ST_MAG_W    = 20'h00010,
      ST_CHECK    = 20'h00020,
      ST_OB_RD    = 20'h00040,
      ST_OB_DIFF  = 20'h00080,
      ST_ATTR     = 20'h00100,
      ST_TERM     = 20'h00200,
      ST_T_MUL    = 20'h00400,
      ST_T_DSTART = 20'h00800,
      ST_T_DWAIT  = 20'h01000,
      ST_T_ACC    = 20'h02000,
      ST_NORM     = 20'h04000,
      ST_N_START  = 20'h08000,
      ST_N_WAIT   = 20'h10000,
      ST_MV_MUL   = 20'h20000,
      ST_MV_ADD   = 20'h40000,
      ST_FINAL    = 20'h80000
   } state_type;

   // Where the magnitude sequence returns to.
   typedef enum logic [1:0] {
      RET_CHECK = 2'd0,
      RET_TERM  = 2'd1,
      RET_NORM  = 2'd2,
      RET_FINAL = 2'd3
   } ret_type;

   state_type state_ff, state_in;
   ret_type   ret_ff, ret_in;

   logic signed [31:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [30:0] step_ff, step_in, attw_ff, attw_in, radius_ff, radius_in;

   logic signed [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [31:0] force_x_ff, force_x_in, force_y_ff, force_y_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          attr_ff, attr_in;
   logic          comp_ff, comp_in;
   logic [1:0]    tstep_ff, tstep_in;
   logic [1:0]    status_ff, status_in;

   logic signed [32:0] mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic [30:0]        w_ff, w_in;
   logic [63:0]        acc_ff, acc_in;
   logic [MAG_W-1:0]   m_ff, m_in;
   logic [DW-1:0]      quo_ff, quo_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // Obstacle table.
   logic signed [31:0] obs_x_mem [MAX_OBSTACLES];
   logic signed [31:0] obs_y_mem [MAX_OBSTACLES];
   logic [30:0]        obs_w_mem [MAX_OBSTACLES];
   logic signed [31:0] rd_x_ff, rd_y_ff;
   logic [30:0]        rd_w_ff;
   logic               mem_we;

   // Shared units.
   logic [32:0]   mul_a;
   logic [30:0]   mul_b;
   logic [63:0]   prod;
   logic          div_start, div_done;
   logic [DW-1:0] div_dividend, div_quotient;
   logic          sqrt_start, sqrt_done;
   logic [31:0]   sqrt_root;

   // Magnitude prescale.
   logic [32:0] ax_abs, ay_abs, or_abs;
   logic [1:0]  mag_shift;
   logic [30:0] ax_sh, ay_sh;

   logic [32:0]        d_abs;
   logic               d_neg;
   logic [30:0]        tval;
   logic signed [32:0] tsigned;
   logic [31:0]        f_abs;
   logic               f_neg;
   logic [30:0]        nval;
   logic [63:0]        mv_val;
   logic signed [65:0] mv_signed;
   logic               term_done;
   logic               last_obs;

   pfps_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .product (prod)
   );

   pfps_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (m_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   pfps_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc_ff + prod),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign ax_abs = abs33(mag_a_ff);
   assign ay_abs = abs33(mag_b_ff);
   assign or_abs = ax_abs | ay_abs;
   assign mag_shift = or_abs[32] ? 2'd2 : (or_abs[31] ? 2'd1 : 2'd0);
   assign ax_sh = 31'(ax_abs >> mag_shift);
   assign ay_sh = 31'(ay_abs >> mag_shift);

   assign d_neg = comp_ff ? mag_b_ff[32] : mag_a_ff[32];
   assign d_abs = comp_ff ? ay_abs : ax_abs;
   assign tval = (quo_ff > DW'(SAT_MAX)) ? SAT_MAX : quo_ff[30:0];
   assign tsigned = d_neg ? -$signed({2'b00, tval}) : $signed({2'b00, tval});

   assign f_neg = comp_ff ? force_y_ff[31] : force_x_ff[31];
   assign f_abs = comp_ff ? 32'(abs33(33'(force_y_ff))) : 32'(abs33(33'(force_x_ff)));
   assign nval = (div_quotient > DW'(SAT_MAX)) ? SAT_MAX : div_quotient[30:0];

   assign mv_val = prod >> FRAC_BITS;
   assign mv_signed = f_neg ? -$signed({2'b00, mv_val}) : $signed({2'b00, mv_val});

   assign last_obs = (CW'(idx_ff) + CW'(1)) >= count_ff;

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      tgt_x_in    = tgt_x_ff;
      tgt_y_in    = tgt_y_ff;
      step_in     = step_ff;
      attw_in     = attw_ff;
      radius_in   = radius_ff;
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      force_x_in  = force_x_ff;
      force_y_in  = force_y_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      attr_in     = attr_ff;
      comp_in     = comp_ff;
      tstep_in    = tstep_ff;
      status_in   = status_ff;
      mag_a_in    = mag_a_ff;
      mag_b_in    = mag_b_ff;
      w_in        = w_ff;
      acc_in      = acc_ff;
      m_in        = m_ff;
      quo_in      = quo_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in = rsp_word_ff;
      mem_we      = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      div_start   = 1'b0;
      div_dividend = '0;
      sqrt_start  = 1'b0;
      term_done   = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_X:      tgt_x_in = csr_wdata;
            CSR_TARGET_Y:      tgt_y_in = csr_wdata;
            CSR_STEP_DISTANCE: step_in = csr_wdata[30:0];
            CSR_ATTRACTION:    attw_in = csr_wdata[30:0];
            CSR_ARRIVE_RADIUS: radius_in = csr_wdata[30:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               status_in = STATUS_OK;
               priority if (req_word.kind == KIND_CLEAR) begin
                  pos_x_in   = '0;
                  pos_y_in   = '0;
                  force_x_in = '0;
                  force_y_in = '0;
                  count_in   = '0;
               end else if (req_word.kind == KIND_ADD) begin
                  if (count_ff >= CW'(MAX_OBSTACLES)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  // A step or an unused kind leaves the state alone here.
               end
               ret_in   = (req_word.kind == KIND_STEP) ? RET_CHECK : RET_FINAL;
               mag_a_in = 33'(tgt_x_ff) - 33'(pos_x_in);
               mag_b_in = 33'(tgt_y_ff) - 33'(pos_y_in);
               state_in = ST_MAG_X;
            end
         end
         ST_MAG_X: begin
            mul_a    = {2'b00, ax_sh};
            mul_b    = ax_sh;
            state_in = ST_MAG_Y;
         end
         ST_MAG_Y: begin
            mul_a    = {2'b00, ay_sh};
            mul_b    = ay_sh;
            acc_in   = prod;
            state_in = ST_MAG_S;
         end
         ST_MAG_S: begin
            sqrt_start = 1'b1;
            state_in   = ST_MAG_W;
         end
         ST_MAG_W: begin
            if (sqrt_done) begin
               m_in = MAG_W'(sqrt_root) << mag_shift;
               unique case (ret_ff)
                  RET_CHECK: state_in = ST_CHECK;
                  RET_TERM:  state_in = ST_TERM;
                  RET_NORM:  state_in = ST_NORM;
                  default:   state_in = ST_FINAL;
               endcase
            end
         end
         ST_CHECK: begin
            idx_in  = '0;
            attr_in = 1'b0;
            if (m_ff <= MAG_W'(radius_ff)) begin
               state_in = ST_FINAL;
            end else if (count_ff == '0) begin
               state_in = ST_ATTR;
            end else begin
               state_in = ST_OB_RD;
            end
         end
         ST_OB_RD: begin
            state_in = ST_OB_DIFF;
         end
         ST_OB_DIFF: begin
            mag_a_in = 33'(pos_x_ff) - 33'(rd_x_ff);
            mag_b_in = 33'(pos_y_ff) - 33'(rd_y_ff);
            w_in     = rd_w_ff;
            ret_in   = RET_TERM;
            state_in = ST_MAG_X;
         end
         ST_ATTR: begin
            mag_a_in = 33'(tgt_x_ff) - 33'(pos_x_ff);
            mag_b_in = 33'(tgt_y_ff) - 33'(pos_y_ff);
            w_in     = attw_ff;
            attr_in  = 1'b1;
            ret_in   = RET_TERM;
            state_in = ST_MAG_X;
         end
         ST_TERM: begin
            comp_in = 1'b0;
            if (m_ff == '0) begin
               status_in = STATUS_ZERO;
               term_done = 1'b1;
            end else begin
               state_in = ST_T_MUL;
            end
         end
         ST_T_MUL: begin
            mul_a    = d_abs;
            mul_b    = w_ff;
            tstep_in = 2'd0;
            state_in = ST_T_DSTART;
         end
         ST_T_DSTART: begin
            div_start    = 1'b1;
            div_dividend = (tstep_ff == 2'd0) ? DW'(prod) : (quo_ff << FRAC_BITS);
            state_in     = ST_T_DWAIT;
         end
         ST_T_DWAIT: begin
            if (div_done) begin
               quo_in = div_quotient;
               if (tstep_ff == 2'd2) begin
                  state_in = ST_T_ACC;
               end else begin
                  tstep_in = tstep_ff + 1'b1;
                  state_in = ST_T_DSTART;
               end
            end
         end
         ST_T_ACC: begin
            if (!comp_ff) begin
               force_x_in = sat32(66'(force_x_ff) + 66'(tsigned));
               comp_in    = 1'b1;
               state_in   = ST_T_MUL;
            end else begin
               force_y_in = sat32(66'(force_y_ff) + 66'(tsigned));
               term_done  = 1'b1;
            end
         end
         ST_NORM: begin
            comp_in = 1'b0;
            if (m_ff == '0) begin
               force_x_in = '0;
               force_y_in = '0;
               state_in   = ST_MV_MUL;
            end else begin
               state_in = ST_N_START;
            end
         end
         ST_N_START: begin
            div_start    = 1'b1;
            div_dividend = DW'(f_abs) << FRAC_BITS;
            state_in     = ST_N_WAIT;
         end
         ST_N_WAIT: begin
            if (div_done) begin
               if (!comp_ff) begin
                  force_x_in = f_neg ? -$signed({1'b0, nval}) : $signed({1'b0, nval});
                  comp_in    = 1'b1;
                  state_in   = ST_N_START;
               end else begin
                  force_y_in = f_neg ? -$signed({1'b0, nval}) : $signed({1'b0, nval});
                  comp_in    = 1'b0;
                  state_in   = ST_MV_MUL;
               end
            end
         end
         ST_MV_MUL: begin
            mul_a    = {1'b0, f_abs};
            mul_b    = step_ff;
            state_in = ST_MV_ADD;
         end
         ST_MV_ADD: begin
            if (!comp_ff) begin
               pos_x_in = sat32(66'(pos_x_ff) + mv_signed);
               comp_in  = 1'b1;
               state_in = ST_MV_MUL;
            end else begin
               pos_y_in = sat32(66'(pos_y_ff) + mv_signed);
               mag_a_in = 33'(tgt_x_ff) - 33'(pos_x_in);
               mag_b_in = 33'(tgt_y_ff) - 33'(pos_y_in);
               ret_in   = RET_FINAL;
               state_in = ST_MAG_X;
            end
         end
         ST_FINAL: begin
            // Load the result only once the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_word_in.pos_x   = pos_x_ff;
               rsp_word_in.pos_y   = pos_y_ff;
               rsp_word_in.arrived = (m_ff <= MAG_W'(radius_ff));
               rsp_word_in.status  = status_ff;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // After a force term, move to the next obstacle, then the attraction
      // term, then the force magnitude.
      if (term_done) begin
         if (attr_ff) begin
            mag_a_in = 33'(force_x_in);
            mag_b_in = 33'(force_y_in);
            ret_in   = RET_NORM;
            state_in = ST_MAG_X;
         end else if (last_obs) begin
            state_in = ST_ATTR;
         end else begin
            idx_in   = idx_ff + 1'b1;
            state_in = ST_OB_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         obs_x_mem[count_ff[IW-1:0]] <= req_word.obstacle_x;
         obs_y_mem[count_ff[IW-1:0]] <= req_word.obstacle_y;
         obs_w_mem[count_ff[IW-1:0]] <= req_word.obstacle_weight;
      end
      rd_x_ff <= obs_x_mem[idx_ff];
      rd_y_ff <= obs_y_mem[idx_ff];
      rd_w_ff <= obs_w_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tgt_x_ff     <= '0;
         tgt_y_ff     <= '0;
         step_ff      <= 31'd65536;
         attw_ff      <= 31'd6553600;
         radius_ff    <= 31'd65536;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         force_x_ff   <= '0;
         force_y_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tgt_x_ff     <= tgt_x_in;
         tgt_y_ff     <= tgt_y_in;
         step_ff      <= step_in;
         attw_ff      <= attw_in;
         radius_ff    <= radius_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         force_x_ff   <= force_x_in;
         force_y_ff   <= force_y_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff      <= ret_in;
      idx_ff      <= idx_in;
      attr_ff     <= attr_in;
      comp_ff     <= comp_in;
      tstep_ff    <= tstep_in;
      status_ff   <= status_in;
      mag_a_ff    <= mag_a_in;
      mag_b_ff    <= mag_b_in;
      w_ff        <= w_in;
      acc_ff      <= acc_in;
      m_ff        <= m_in;
      quo_ff      <= quo_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_OBSTACLES))
      else $error("obstacle count beyond table depth");

   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == ST_FINAL))
      else $error("result loaded outside the final state");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_T_DWAIT || state_ff == ST_N_WAIT))
      else $error("divider finished while sequencer was not waiting");
`endif

endmodule

### rtl/pfps_mul.sv
// Shared unsigned multiplier of the path stepper, 33 by 31 bits, with a
// registered product. Self-contained.
`timescale 1ns / 1ps

module pfps_mul (
   input  logic        clock,
   input  logic [32:0] a,
   input  logic [30:0] b,
   output logic [63:0] product
);
   logic [63:0] product_ff;
   logic [63:0] product_in;

   assign product_in = 64'(a) * 64'(b);
   assign product = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

### rtl/pfps_div.sv
// Restoring divider of the path stepper, one quotient bit per cycle.
// Uses pfps_pkg for the divisor width.
`timescale 1ns / 1ps

module pfps_div #(
   parameter int DW = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DW-1:0]           dividend,
   input  logic [pfps_pkg::MAG_W-1:0] divisor,
   output logic                    done,
   output logic [DW-1:0]           quotient
);
   import pfps_pkg::*;

   localparam int CNTW = $clog2(DW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]   quo_ff, quo_in;
   logic [MAG_W-1:0] rem_ff, rem_in;
   logic [MAG_W:0]  trial;
   logic [MAG_W:0]  diff;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(DW);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (!diff[MAG_W]) begin
            rem_in = diff[MAG_W-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[MAG_W-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/pfps_sqrt.sv
// Bit-pair integer square root of the path stepper, truncating, one result
// bit per cycle. Self-contained.
`timescale 1ns / 1ps

module pfps_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] n_ff, n_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] rb;

   assign rb = r_ff + b_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      r_in    = r_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd32;
         n_in    = radicand;
         r_in    = '0;
         b_in    = 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (n_ff >= rb) begin
            n_in = n_ff - rb;
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in   = b_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      n_ff <= n_in;
      r_ff <= r_in;
      b_ff <= b_in;
   end

   assign done = done_ff;
   assign root = r_ff[31:0];

endmodule
